// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/tlpq_pkg.sv =====
// ----------------------------------------------------------------------------
// tlpq_pkg
// Types, sizes and codes shared by the two-level priority queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tlpq_pkg;

  localparam int DEPTH  = 16;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int WORD_W = 32;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [WORD_W-1:0] word_t;

  localparam logic       CMD_PUSH = 1'b0;
  localparam logic       CMD_POP  = 1'b1;
  localparam logic [1:0] LVL_HIGH = 2'd1;
  localparam logic [1:0] LVL_LOW  = 2'd2;

  typedef enum logic [1:0] {
    ST_PUSHED  = 2'd0,
    ST_DROPPED = 2'd1,
    ST_POPPED  = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_RESULT
  } state_t;

  // One access to a level store; write and read never share a cycle.
  typedef struct packed {
    logic  we;
    logic  re;
    addr_t addr;
    word_t wdata;
  } mem_req_t;

endpackage

// ===== hw/rtl/tlpq_store.sv =====
// ----------------------------------------------------------------------------
// tlpq_store
// Storage for one priority level: DEPTH words, one access per cycle,
// registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tlpq_store import tlpq_pkg::*; (
  input  logic     clk,
  input  mem_req_t req,
  output word_t    rdata
);

  word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= mem[req.addr];
    end
  end

endmodule

// ===== hw/rtl/tlpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// tlpq_ctrl
// Sequencer for the priority queue: pointers, fill counts, store accesses
// and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tlpq_ctrl import tlpq_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               cmd,
  input  logic signed [31:0] value_in,
  input  logic        [1:0]  level,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] value_out,
  output logic        [1:0]  status,
  output mem_req_t           high_req,
  output mem_req_t           low_req,
  input  word_t              high_rdata,
  input  word_t              low_rdata
);

  state_t  state, state_next;
  addr_t   high_head, high_tail, low_head, low_tail;
  cnt_t    high_count, low_count;
  logic    pop_sel;
  word_t   res_value;
  status_t res_status;

  logic accept, is_push, push_high, push_low, pop_high, pop_low;
  logic out_free, out_load;

  function automatic addr_t next_index(addr_t p);
    return (p == addr_t'(DEPTH - 1)) ? '0 : addr_t'(p + 1'b1);
  endfunction

  assign accept    = in_valid && !in_stall;
  assign is_push   = (cmd == CMD_PUSH);
  assign push_high = is_push && (level == LVL_HIGH) && (high_count != cnt_t'(DEPTH));
  assign push_low  = is_push && (level == LVL_LOW) && (low_count != cnt_t'(DEPTH));
  assign pop_high  = !is_push && (high_count != '0);
  assign pop_low   = !is_push && (high_count == '0) && (low_count != '0);
  assign out_free  = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = (pop_high || pop_low) ? S_READ : S_RESULT;
        end
      end
      S_READ:   state_next = S_RESULT;
      S_RESULT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall       = (state != S_IDLE);
    out_load       = (state == S_RESULT) && out_free;
    high_req.we    = accept && push_high;
    high_req.re    = accept && pop_high;
    high_req.addr  = pop_high ? high_head : high_tail;
    high_req.wdata = word_t'(value_in);
    low_req.we     = accept && push_low;
    low_req.re     = accept && pop_low;
    low_req.addr   = pop_low ? low_head : low_tail;
    low_req.wdata  = word_t'(value_in);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      high_head  <= '0;
      high_tail  <= '0;
      high_count <= '0;
      low_head   <= '0;
      low_tail   <= '0;
      low_count  <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        pop_sel <= pop_low;
        if (push_high) begin
          high_tail  <= next_index(high_tail);
          high_count <= cnt_t'(high_count + 1'b1);
        end
        if (push_low) begin
          low_tail  <= next_index(low_tail);
          low_count <= cnt_t'(low_count + 1'b1);
        end
        if (pop_high) begin
          high_head  <= next_index(high_head);
          high_count <= cnt_t'(high_count - 1'b1);
        end
        if (pop_low) begin
          low_head  <= next_index(low_head);
          low_count <= cnt_t'(low_count - 1'b1);
        end
        if (is_push) begin
          res_value  <= '0;
          res_status <= (push_high || push_low) ? ST_PUSHED : ST_DROPPED;
        end else begin
          // Both levels empty; a pop that finds data is finished in S_READ.
          res_value  <= '1;
          res_status <= ST_EMPTY;
        end
      end
      if (state == S_READ) begin
        res_value  <= pop_sel ? low_rdata : high_rdata;
        res_status <= ST_POPPED;
      end
      if (out_load) begin
        value_out <= res_value;
        status    <= res_status;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/two_level_priority_queue_top.sv =====
// ----------------------------------------------------------------------------
// two_level_priority_queue_top
// Strict two-level priority queue built on two word stores.
// ----------------------------------------------------------------------------
// Each input word is a push (cmd 0) of value_in to level 1 (high) or level 2
// (low), or a pop (cmd 1). Every input word yields exactly one result word.
// A push returns value_out 0 with status 0, or status 1 when the selected
// level already holds DEPTH entries or the level is neither 1 nor 2. A pop
// returns the oldest high-level value, else the oldest low-level value, with
// status 2; with both levels empty it returns -1 with status 3. Both levels
// are circular buffers kept in their own single-port stores with a registered
// read. Items are handled one at a time: a push passes the sequencer states
// S_IDLE and S_RESULT, and a pop that finds data also passes S_READ, the
// store read; while the output word is stalled, the next item is
// still accepted and worked up to its result, then waits there. The stores
// need no clearing after reset, since an entry is only read after it has been
// written; the block takes input words from the first cycle after reset.
// Reads and writes of a store happen in separate items, so no forwarding is
// needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module two_level_priority_queue_top import tlpq_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               cmd,
  input  logic signed [31:0] value_in,
  input  logic        [1:0]  level,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] value_out,
  output logic        [1:0]  status
);

  mem_req_t high_req, low_req;
  word_t    high_rdata, low_rdata;

  // Sequencer: decides each word, owns the pointers and the result register.
  tlpq_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .cmd        (cmd),
    .value_in   (value_in),
    .level      (level),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .value_out  (value_out),
    .status     (status),
    .high_req   (high_req),
    .low_req    (low_req),
    .high_rdata (high_rdata),
    .low_rdata  (low_rdata)
  );

  // High-priority level store.
  tlpq_store u_high_store (
    .clk   (clk),
    .req   (high_req),
    .rdata (high_rdata)
  );

  // Low-priority level store.
  tlpq_store u_low_store (
    .clk   (clk),
    .req   (low_req),
    .rdata (low_rdata)
  );

endmodule

// ===== hw/rtl/tlpq_checker.sv =====
// ----------------------------------------------------------------------------
// tlpq_checker
// Port-level checks for the two-level priority queue, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tlpq_checker import tlpq_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               cmd,
  input logic signed [31:0] value_in,
  input logic        [1:0]  level,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] value_out,
  input logic        [1:0]  status
);

  `ASSERT_ALWAYS(a_reset_clears_out, rst |=> !out_valid, "output valid after reset")
  `ASSERT_CLK(a_out_hold, out_valid && out_stall |=> out_valid && $stable(value_out) && $stable(status), "stalled output word changed")
  `ASSERT_CLK(a_busy_after_accept, in_valid && !in_stall |=> in_stall, "second word taken while busy")
  `ASSERT_CLK(a_empty_value, out_valid && (status == ST_EMPTY) |-> value_out == -32'sd1, "empty pop value is not -1")
  `ASSERT_CLK(a_push_value, out_valid && (status == ST_PUSHED || status == ST_DROPPED) |-> value_out == 32'sd0, "push result value is not 0")

endmodule

bind two_level_priority_queue_top tlpq_checker u_checker (.*);

// ===== tb/two_level_priority_queue_top_test.sv =====
// ----------------------------------------------------------------------------
// two_level_priority_queue_top_test
// Self-checking bench for the strict two-level priority queue. A queue of
// words feeds a clocked driver. Every accepted word runs through a model
// of both level buffers, and that model gives the expected result word. A
// clocked monitor checks each result word, in order, against those
// expectations. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module two_level_priority_queue_top_test;
  import tlpq_pkg::*;

  // Stimulus size, run limit and the quiet time that is allowed after the last
  // result word. The quiet time is long enough to catch any stray result word.
  localparam int RANDOM_WORDS = 1800;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 12;

  // One input word and one result word, with the port widths of the block.
  typedef struct {
    logic               cmd;
    logic signed [31:0] value;
    logic        [1:0]  level;
  } op_word_t;

  typedef struct {
    logic signed [31:0] value;
    status_t            status;
  } result_word_t;

  // Every input of the block has a known value from time zero.
  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic               cmd       = CMD_PUSH;
  logic signed [31:0] value_in  = '0;
  logic        [1:0]  level     = LVL_HIGH;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] value_out;
  logic        [1:0]  status;

  op_word_t     words_pending[$];
  result_word_t results_due[$];

  int total_words = 0;
  int words_sent  = 0;
  int error_count = 0;
  int cycle_count = 0;
  // Idling phase: 0 = light sender gaps and heavy output stalls, 1 = the other
  // way round, 2 = neither side idles.
  int phase       = 0;

  // The model's own copy of the two level buffers. Index 0 holds the high
  // level and index 1 the low level.
  logic signed [31:0] level_mem [2][DEPTH];
  int level_head  [2] = '{0, 0};
  int level_tail  [2] = '{0, 0};
  int level_count [2] = '{0, 0};

  two_level_priority_queue_top DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .value_in  (value_in),
    .level     (level),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .value_out (value_out),
    .status    (status)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int sender_idle_pct(int p);
    case (p)
      0: return 15;
      1: return 49;
      default: return 0;
    endcase
  endfunction

  function automatic int receiver_idle_pct(int p);
    case (p)
      0: return 49;
      1: return 15;
      default: return 0;
    endcase
  endfunction

  // Apply one accepted word to the model buffers. The result word that the
  // block owes for it goes to the back of results_due.
  task automatic queue_model_step(input op_word_t w);
    result_word_t r;
    int           li;
    r.value  = '0;
    r.status = ST_DROPPED;
    if (w.cmd == CMD_PUSH) begin
      // A level other than high or low selects no buffer, so the push is
      // dropped. A push to a full buffer is dropped the same way.
      if (w.level == LVL_HIGH || w.level == LVL_LOW) begin
        li = (w.level == LVL_HIGH) ? 0 : 1;
        if (level_count[li] < DEPTH) begin
          level_mem[li][level_tail[li]] = w.value;
          level_tail[li] = (level_tail[li] == DEPTH - 1) ? 0 : level_tail[li] + 1;
          level_count[li]++;
          r.status = ST_PUSHED;
        end
      end
    end else begin
      // Strict priority: the low level is served only while high is empty.
      if (level_count[0] > 0 || level_count[1] > 0) begin
        li = (level_count[0] > 0) ? 0 : 1;
        r.value = level_mem[li][level_head[li]];
        level_head[li] = (level_head[li] == DEPTH - 1) ? 0 : level_head[li] + 1;
        level_count[li]--;
        r.status = ST_POPPED;
      end else begin
        r.value  = -32'sd1;
        r.status = ST_EMPTY;
      end
    end
    results_due.push_back(r);
  endtask

  task automatic add_word(input logic c, input logic signed [31:0] v, input logic [1:0] l);
    op_word_t w;
    w.cmd   = c;
    w.value = v;
    w.level = l;
    words_pending.push_back(w);
  endtask

  // Mostly full-range random values, with the sign and zero corners mixed in.
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 11))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return -32'sd1;
      3: return 32'sd0;
      default: return $urandom;
    endcase
  endfunction

  // Driver. A word stays on the inputs until the block accepts it. The model
  // sees the word at the edge where it is accepted. A fresh word, or a gap,
  // is put up only when the input slot is free.
  always @(posedge clk) begin
    op_word_t w;
    op_word_t taken;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        taken.cmd   = cmd;
        taken.value = value_in;
        taken.level = level;
        queue_model_step(taken);
      end
      if (!in_valid || !in_stall) begin
        if (words_pending.size() > 0 && $urandom_range(0, 99) >= sender_idle_pct(phase)) begin
          w = words_pending.pop_front();
          cmd      <= w.cmd;
          value_in <= w.value;
          level    <= w.level;
          in_valid <= 1'b1;
          words_sent++;
          phase <= (words_sent * 3 / total_words > 2) ? 2 : words_sent * 3 / total_words;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor. Each accepted result word is checked, field by field, against
  // the oldest expectation. The output stall is drawn fresh every cycle.
  always @(posedge clk) begin
    result_word_t exp_word;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result word, expected none, actual value %0d status %0d",
                   $time, value_out, status);
          error_count++;
        end else begin
          exp_word = results_due.pop_front();
          if (value_out !== exp_word.value) begin
            $display("%0t: value_out mismatch, expected %0d, actual %0d",
                     $time, exp_word.value, value_out);
            error_count++;
          end
          if (status !== exp_word.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, exp_word.status, status);
            error_count++;
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < receiver_idle_pct(phase));
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: run limit of %0d cycles reached", $time, CYCLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int           burst_len;
    int           push_pct;
    int           high_pct;
    int           i;
    result_word_t left;

    // Directed opening. A pop on an empty queue comes first. Then come pushes
    // with the two levels that select no buffer, two low-level words, and
    // enough high-level words to fill that buffer and overflow it once. The
    // last pop must take the oldest high word even though low words wait.
    add_word(CMD_POP, 32'sh12345678, LVL_LOW);
    add_word(CMD_PUSH, 32'sh7fffffff, 2'd0);
    add_word(CMD_PUSH, 32'sh80000000, 2'd3);
    add_word(CMD_PUSH, 32'sh80000000, LVL_LOW);
    add_word(CMD_PUSH, -32'sd1, LVL_LOW);
    for (i = 0; i < DEPTH; i++) begin
      case (i)
        0: add_word(CMD_PUSH, 32'sh7fffffff, LVL_HIGH);
        1: add_word(CMD_PUSH, 32'sd0, LVL_HIGH);
        2: add_word(CMD_PUSH, -32'sd1, LVL_HIGH);
        3: add_word(CMD_PUSH, 32'sh80000000, LVL_HIGH);
        default: add_word(CMD_PUSH, $urandom, LVL_HIGH);
      endcase
    end
    add_word(CMD_PUSH, 32'sh55aa55aa, LVL_HIGH);
    add_word(CMD_POP, $urandom, 2'($urandom));

    // Random part in bursts. Push-heavy bursts fill the buffers to the full
    // point and pop-heavy bursts drain them through the empty point, so the
    // pointers wrap many times. Balanced bursts sit in between. The mix of
    // levels shifts from burst to burst, and a few pushes carry a level that
    // selects no buffer. Pops carry random values and levels in the fields
    // that the block ignores.
    while (words_pending.size() < 23 + RANDOM_WORDS) begin
      burst_len = $urandom_range(8, 60);
      case ($urandom_range(0, 2))
        0: push_pct = 80;
        1: push_pct = 20;
        default: push_pct = 50;
      endcase
      high_pct = $urandom_range(0, 100);
      for (i = 0; i < burst_len; i++) begin
        if ($urandom_range(0, 99) < push_pct) begin
          if ($urandom_range(0, 99) < 5)
            add_word(CMD_PUSH, pick_value(), ($urandom_range(0, 1) == 0) ? 2'd0 : 2'd3);
          else if ($urandom_range(0, 99) < high_pct)
            add_word(CMD_PUSH, pick_value(), LVL_HIGH);
          else
            add_word(CMD_PUSH, pick_value(), LVL_LOW);
        end else begin
          add_word(CMD_POP, $urandom, 2'($urandom));
        end
      end
    end
    total_words = words_pending.size();

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Wait until every word has gone in and every result word has come out.
    // Then leave a short quiet time in which a stray result word would still
    // be flagged.
    do begin
      @(posedge clk);
    end while (words_pending.size() != 0 || in_valid || results_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (results_due.size() != 0) begin
      left = results_due[0];
      $display("%0t: %0d result words missing, expected value %0d status %0d, actual none",
               $time, results_due.size(), left.value, left.status);
      error_count++;
    end

    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
